// ===== design/scd_pkg.sv =====
package scd_pkg;

  // Chain length limit and derived widths
  localparam int MAX_PARTICLES = 16;
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 2);
  localparam int IDX_W         = (CNT_W > 4) ? CNT_W : 4;

  // Field widths
  localparam int DATA_W = 24;
  localparam int CFG_W  = 23;
  localparam int ACC_W  = 40;

  // Iteration counts of the shared unit
  localparam int MUL_STEPS  = 26;
  localparam int DIV_STEPS  = 60;
  localparam int SQRT_STEPS = 25;

  // Register indexes
  localparam logic [1:0] REG_GRAVITY   = 2'd0;
  localparam logic [1:0] REG_DRAG      = 2'd1;
  localparam logic [1:0] REG_STIFFNESS = 2'd2;
  localparam logic [1:0] REG_REST      = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] GRAVITY_RST   = 23'd65536;
  localparam logic [CFG_W-1:0] DRAG_RST      = 23'd6554;
  localparam logic [CFG_W-1:0] STIFFNESS_RST = 23'd196608;
  localparam logic [CFG_W-1:0] REST_RST      = 23'd6554;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SETUP,
    S_DRAG,
    S_DRAG_ACC,
    S_SPRING,
    S_SQ,
    S_SQ_ACC,
    S_ROOT,
    S_ROOT_DONE,
    S_MAG,
    S_MAG_DONE,
    S_COMP,
    S_COMP_DONE,
    S_DIV_DONE,
    S_NEXT_SPRING,
    S_FINISH,
    S_UPDATE,
    S_MUL_RUN,
    S_DIV_RUN,
    S_SQRT_RUN
  } state_t;

endpackage

// ===== design/spring_chain_derivative.sv =====
// Channel   Handshake                    Payload
// item      item_valid / item_ready      pos_x..vel_z, chain_end
// result    result_valid / result_ready  particle_index, dpos_*, dvel_*, last_result, overflow
// config    write_enable                 write_index, write_data
//
// One shift-add multiplier, restoring divider and root unit is shared by all steps.
// An item with no result only shifts the window, and a fixed particle goes straight to its result;
// a moving particle runs drag and then each spring in turn (sqrt, scale, 3 divides).
// Synchronous active-high reset clears the particle window and the count.
// item_ready is high only between items; a result not yet taken holds the sequencer
// in its finish step, so the next item waits.
module spring_chain_derivative (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic signed [23:0]  pos_x,
  input  logic signed [23:0]  pos_y,
  input  logic signed [23:0]  pos_z,
  input  logic signed [23:0]  vel_x,
  input  logic signed [23:0]  vel_y,
  input  logic signed [23:0]  vel_z,
  input  logic                chain_end,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [3:0]          particle_index,
  output logic signed [23:0]  dpos_x,
  output logic signed [23:0]  dpos_y,
  output logic signed [23:0]  dpos_z,
  output logic signed [23:0]  dvel_x,
  output logic signed [23:0]  dvel_y,
  output logic signed [23:0]  dvel_z,
  output logic                last_result,
  output logic                overflow,
  input  logic                write_enable,
  input  logic [1:0]          write_index,
  input  logic [22:0]         write_data
);
  import scd_pkg::*;

  function automatic logic [24:0] abs25(input logic signed [24:0] x);
    return x[24] ? 25'(-x) : 25'(x);
  endfunction

  state_t state, state_next, ret;

  // Configuration
  logic [CFG_W-1:0] gravity, drag_coeff, stiffness, rest_length;

  // Window and latched input
  logic signed [DATA_W-1:0] prior_pos [3];
  logic signed [DATA_W-1:0] older_pos [3];
  logic signed [DATA_W-1:0] prior_vel [3];
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] in_pos [3];
  logic signed [DATA_W-1:0] in_vel [3];
  logic                     in_end;
  logic [CNT_W-1:0]         c_lat;

  // Job control
  logic       job;
  logic       sp;
  logic [1:0] comp;

  // Working values
  logic signed [ACC_W-1:0] acc [3];
  logic signed [24:0]      d [3];
  logic [49:0]             sum;
  logic [24:0]             len;
  logic signed [34:0]      m;

  // Shared unit
  logic [59:0] w;
  logic [33:0] h;
  logic [33:0] mc;
  logic [25:0] r;
  logic [5:0]  cnt;

  // Job selection
  logic                     fixed, has_left, has_right;
  logic [CNT_W-1:0]         idx_raw, idx_sat;
  logic                     idx_ovf;
  logic signed [DATA_W-1:0] e_pos [3];
  logic signed [DATA_W-1:0] e_vel [3];
  logic signed [DATA_W-1:0] nbr [3];

  assign fixed     = job ? (c_lat == '0) : (c_lat == CNT_W'(1));
  assign has_left  = job ? (c_lat != '0) : 1'b1;
  assign has_right = !job;
  assign idx_raw   = job ? c_lat : c_lat - CNT_W'(1);
  assign idx_ovf   = idx_raw >= CNT_W'(MAX_PARTICLES);
  assign idx_sat   = idx_ovf ? CNT_W'(MAX_PARTICLES - 1) : idx_raw;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_pos[i] = job ? in_pos[i] : prior_pos[i];
      e_vel[i] = job ? in_vel[i] : prior_vel[i];
      nbr[i]   = sp ? in_pos[i] : (job ? prior_pos[i] : older_pos[i]);
    end
  end

  // Operand selection and signed rounding of the product
  logic [59:0]        prod;
  logic signed [25:0] diff;
  logic [33:0]        mul_a;
  logic [25:0]        mul_b;
  logic               mul_neg;
  logic signed [50:0] p51, sv, rnd;
  logic [34:0]        mul_sum;
  logic [25:0]        div_t;
  logic               div_ge;
  logic [27:0]        sq_t, sq_trial;
  logic               sq_ge;

  assign prod = {h, w[25:0]};
  assign diff = $signed({1'b0, len}) - $signed({3'b0, rest_length});

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (state)
      S_DRAG, S_DRAG_ACC: begin
        mul_a   = 34'(drag_coeff);
        mul_b   = {1'b0, abs25({e_vel[comp][23], e_vel[comp]})};
        mul_neg = e_vel[comp][23];
      end
      S_SQ: begin
        mul_a = {9'b0, abs25(d[comp])};
        mul_b = {1'b0, abs25(d[comp])};
      end
      S_MAG, S_MAG_DONE: begin
        mul_a   = 34'(stiffness);
        mul_b   = diff[25] ? 26'(-diff) : 26'(diff);
        mul_neg = diff[25];
      end
      S_COMP: begin
        mul_a = m[34] ? 34'(-m) : 34'(m);
        mul_b = {1'b0, abs25(d[comp])};
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  assign p51 = $signed({1'b0, prod[49:0]});
  assign sv  = mul_neg ? -p51 : p51;
  assign rnd = (sv + 51'sd32768) >>> 16;

  assign mul_sum  = {1'b0, h} + (w[0] ? {1'b0, mc} : 35'd0);
  assign div_t    = {r[24:0], w[59]};
  assign div_ge   = div_t >= {1'b0, len};
  assign sq_t     = {r, w[49:48]};
  assign sq_trial = {1'b0, h[24:0], 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  // Saturation of the final sums
  logic signed [23:0] sat [3];
  logic [2:0]         sat_hit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (acc[i] > 40'sd8388607) begin
        sat[i]     = 24'sh7FFFFF;
        sat_hit[i] = 1'b1;
      end else if (acc[i] < -40'sd8388608) begin
        sat[i]     = -24'sh800000;
        sat_hit[i] = 1'b1;
      end else begin
        sat[i]     = acc[i][23:0];
        sat_hit[i] = 1'b0;
      end
    end
  end

  logic out_free;
  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = (count != '0 || chain_end) ? S_SETUP : S_UPDATE;
        end
      end
      S_SETUP:     state_next = fixed ? S_FINISH : S_DRAG;
      S_DRAG:      state_next = S_MUL_RUN;
      S_DRAG_ACC: begin
        if (comp != 2'd2) begin
          state_next = S_DRAG;
        end else if (has_left || has_right) begin
          state_next = S_SPRING;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SPRING:    state_next = S_SQ;
      S_SQ:        state_next = S_MUL_RUN;
      S_SQ_ACC:    state_next = (comp == 2'd2) ? S_ROOT : S_SQ;
      S_ROOT:      state_next = S_SQRT_RUN;
      S_ROOT_DONE: state_next = (h[24:0] == '0) ? S_NEXT_SPRING : S_MAG;
      S_MAG:       state_next = S_MUL_RUN;
      S_MAG_DONE:  state_next = S_COMP;
      S_COMP:      state_next = S_MUL_RUN;
      S_COMP_DONE: state_next = S_DIV_RUN;
      S_DIV_DONE:  state_next = (comp == 2'd2) ? S_NEXT_SPRING : S_COMP;
      S_NEXT_SPRING: begin
        state_next = (!sp && has_right) ? S_SPRING : S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = (!job && in_end) ? S_SETUP : S_UPDATE;
        end
      end
      S_UPDATE:    state_next = S_IDLE;
      S_MUL_RUN, S_DIV_RUN, S_SQRT_RUN: begin
        if (cnt == 6'd1) begin
          state_next = ret;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity     <= GRAVITY_RST;
      drag_coeff  <= DRAG_RST;
      stiffness   <= STIFFNESS_RST;
      rest_length <= REST_RST;
    end else if (write_enable) begin
      unique case (write_index)
        REG_GRAVITY:   gravity     <= write_data;
        REG_DRAG:      drag_coeff  <= write_data;
        REG_STIFFNESS: stiffness   <= write_data;
        REG_REST:      rest_length <= write_data;
        default:       gravity     <= gravity;
      endcase
    end
  end

  // Window and count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < 3; i++) begin
        prior_pos[i] <= '0;
        older_pos[i] <= '0;
        prior_vel[i] <= '0;
      end
    end else if (state == S_UPDATE) begin
      if (in_end) begin
        count <= '0;
      end else begin
        count <= (c_lat < CNT_W'(MAX_PARTICLES + 1)) ? c_lat + CNT_W'(1)
                                                      : CNT_W'(MAX_PARTICLES + 1);
        for (int i = 0; i < 3; i++) begin
          older_pos[i] <= prior_pos[i];
          prior_pos[i] <= in_pos[i];
          prior_vel[i] <= in_vel[i];
        end
      end
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        in_pos[0] <= pos_x;
        in_pos[1] <= pos_y;
        in_pos[2] <= pos_z;
        in_vel[0] <= vel_x;
        in_vel[1] <= vel_y;
        in_vel[2] <= vel_z;
        in_end    <= chain_end;
        c_lat     <= count;
        job       <= (count == '0);
      end
      S_SETUP: begin
        acc[0] <= '0;
        acc[1] <= -$signed({17'b0, gravity});
        acc[2] <= '0;
        comp   <= '0;
      end
      S_DRAG, S_SQ, S_MAG, S_COMP: begin
        h   <= '0;
        w   <= {34'b0, mul_b};
        mc  <= mul_a;
        cnt <= 6'(MUL_STEPS);
        unique case (state)
          S_DRAG:  ret <= S_DRAG_ACC;
          S_SQ:    ret <= S_SQ_ACC;
          S_MAG:   ret <= S_MAG_DONE;
          default: ret <= S_COMP_DONE;
        endcase
      end
      S_DRAG_ACC: begin
        acc[comp] <= acc[comp] - rnd[ACC_W-1:0];
        comp      <= comp + 2'd1;
        sp        <= !has_left;
      end
      S_SPRING: begin
        for (int i = 0; i < 3; i++) begin
          d[i] <= $signed({e_pos[i][23], e_pos[i]}) - $signed({nbr[i][23], nbr[i]});
        end
        sum  <= '0;
        comp <= '0;
      end
      S_SQ_ACC: begin
        sum  <= sum + prod[49:0];
        comp <= comp + 2'd1;
      end
      S_ROOT: begin
        w   <= {10'b0, sum};
        r   <= '0;
        h   <= '0;
        cnt <= 6'(SQRT_STEPS);
        ret <= S_ROOT_DONE;
      end
      S_ROOT_DONE: len <= h[24:0];
      S_MAG_DONE: begin
        m    <= rnd[34:0];
        comp <= '0;
      end
      S_COMP_DONE: begin
        w   <= prod + {36'b0, len[24:1]};
        r   <= '0;
        cnt <= 6'(DIV_STEPS);
        ret <= S_DIV_DONE;
      end
      S_DIV_DONE: begin
        if (m[34] ^ d[comp][24]) begin
          acc[comp] <= acc[comp] + $signed(w[ACC_W-1:0]);
        end else begin
          acc[comp] <= acc[comp] - $signed(w[ACC_W-1:0]);
        end
        comp <= comp + 2'd1;
      end
      S_NEXT_SPRING: sp <= 1'b1;
      S_FINISH: begin
        if (out_free) begin
          job <= 1'b1;
        end
      end
      S_MUL_RUN: begin
        h       <= mul_sum[34:1];
        w[25:0] <= {mul_sum[0], w[25:1]};
        cnt     <= cnt - 6'd1;
      end
      S_DIV_RUN: begin
        r   <= {1'b0, div_ge ? 25'(div_t - {1'b0, len}) : div_t[24:0]};
        w   <= {w[58:0], div_ge};
        cnt <= cnt - 6'd1;
      end
      S_SQRT_RUN: begin
        r   <= sq_ge ? 26'(sq_t - sq_trial) : sq_t[25:0];
        h   <= {9'b0, h[23:0], sq_ge};
        w   <= {w[57:0], 2'b00};
        cnt <= cnt - 6'd1;
      end
      default: cnt <= cnt;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      particle_index <= idx_sat[3:0];
      dpos_x         <= fixed ? '0 : e_vel[0];
      dpos_y         <= fixed ? '0 : e_vel[1];
      dpos_z         <= fixed ? '0 : e_vel[2];
      dvel_x         <= fixed ? '0 : sat[0];
      dvel_y         <= fixed ? '0 : sat[1];
      dvel_z         <= fixed ? '0 : sat[2];
      last_result    <= job;
      overflow       <= idx_ovf | (!fixed & (|sat_hit));
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PARTICLES + 1))
    else $error("particle count beyond limit");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_RUN || state == S_DIV_RUN || state == S_SQRT_RUN) |-> cnt != '0)
    else $error("shared unit running with zero step count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("ready while an item is in work");

  a_fixed_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && particle_index == 4'd0 && !overflow) |->
      (dvel_x == 24'sd0 && dvel_y == 24'sd0 && dvel_z == 24'sd0))
    else $error("fixed particle with nonzero force");
`endif

endmodule
